// ===== rtl/dspv_pkg.sv =====
// Shared types, character codes and digit helpers for the date/time text parser.
`default_nettype none

package dspv_pkg;

    // Text shape: YYYY-MM-DD/hh:mm
    localparam int unsigned TEXT_LEN = 16;
    localparam int unsigned POS_SAT  = 17;
    localparam int unsigned POS_W    = 5;

    localparam logic [POS_W-1:0] POS_TEXT_LEN = POS_W'(TEXT_LEN);
    localparam logic [POS_W-1:0] POS_MAX      = POS_W'(POS_SAT);
    localparam logic [POS_W-1:0] POS_DASH_A   = 5'd4;
    localparam logic [POS_W-1:0] POS_DASH_B   = 5'd7;
    localparam logic [POS_W-1:0] POS_SLASH    = 5'd10;
    localparam logic [POS_W-1:0] POS_COLON    = 5'd13;
    localparam logic [POS_W-1:0] POS_CENT_END = 5'd2;

    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [13:0] YEAR_MIN = 14'd1000;
    localparam logic [13:0] YEAR_MAX = 14'd9999;

    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_APR = 4'd4;
    localparam logic [3:0] MON_JUN = 4'd6;
    localparam logic [3:0] MON_SEP = 4'd9;
    localparam logic [3:0] MON_NOV = 4'd11;

    // Finished text, handed from the accumulate stage to the check stage
    typedef struct packed {
        logic        fmt_ok;
        logic [13:0] year;
        logic [6:0]  century;
        logic [6:0]  yy;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
    } dspv_snap_t;

    typedef struct packed {
        logic        ok;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } dspv_result_t;

    // acc * 10 + d, truncated to the accumulator width
    function automatic logic [13:0] add_digit14(input logic [13:0] acc, input logic [3:0] d);
        logic [13:0] sum;
        sum = (acc << 3) + (acc << 1) + {10'd0, d};
        return sum;
    endfunction

    function automatic logic [6:0] add_digit7(input logic [6:0] acc, input logic [3:0] d);
        logic [6:0] sum;
        sum = (acc << 3) + (acc << 1) + {3'd0, d};
        return sum;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dspv_check.sv =====
// Calendar and range checks on one finished date/time text.
`default_nettype none

module dspv_check (
    input  dspv_pkg::dspv_snap_t   snap,
    output dspv_pkg::dspv_result_t res
);
    import dspv_pkg::*;

    logic       leap;
    logic [4:0] month_len;
    logic [3:0] mon4;
    logic       ok;

    // Year divisible by 100 falls back to the century digits for the 400 rule
    assign leap = (snap.yy != 7'd0) ? (snap.yy[1:0] == 2'd0) : (snap.century[1:0] == 2'd0);
    assign mon4 = snap.month[3:0];

    always_comb begin
        case (mon4)
            MON_FEB: month_len = leap ? 5'd29 : 5'd28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: month_len = 5'd30;
            default: month_len = 5'd31;
        endcase
    end

    assign ok = snap.fmt_ok
             && (snap.year >= YEAR_MIN) && (snap.year <= YEAR_MAX)
             && (snap.month >= 7'd1) && (snap.month <= 7'd12)
             && (snap.day >= 7'd1) && (snap.day <= {2'd0, month_len})
             && (snap.hour <= 7'd23) && (snap.minute <= 7'd59);

    always_comb begin
        res.ok     = ok;
        res.year   = ok ? snap.year : '0;
        res.month  = ok ? snap.month[3:0] : '0;
        res.day    = ok ? snap.day[4:0] : '0;
        res.hour   = ok ? snap.hour[4:0] : '0;
        res.minute = ok ? snap.minute[5:0] : '0;
    end

endmodule

`default_nettype wire

// ===== rtl/datetime_string_parse_validate_unit.sv =====
// Top level of the streaming YYYY-MM-DD/hh:mm text parser and validator.
//
// Usage:
//   The s_ channel carries one text character per request in s_tdata[7:0];
//   s_tlast marks the final character of a text. Every character is taken
//   into the digit accumulators as it arrives; nothing comes out until the
//   last one. On the last character one result request leaves on the m_
//   channel: m_tuser is the ok flag, m_tdata holds year, month, day, hour
//   and minute, all zero when any format or calendar check failed.
//   Throughput is one character per cycle while s_tready is high, with
//   no gap between texts. The edge that accepts the last character
//   loads the finished text into the handoff register; the checked
//   result then moves into the output register, which raises m_tvalid.
//   When the receiver stalls, the result holds in the output register and a
//   second finished text may wait in the handoff register; s_tready drops
//   only while both are full. Reset clears the position counter, error flag,
//   accumulators and both valid flags, so the first character after reset
//   starts a new text.
`default_nettype none

module datetime_string_parse_validate_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_byte
    input  wire logic        s_tlast,   // last_char
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [13:0] year_out, [17:14] month_out, [22:18] day_out, [27:23] hour_out,
    // [33:28] minute_out, [39:34] zero
    output logic [39:0]      m_tdata,
    output logic             m_tuser    // date_ok
);
    import dspv_pkg::*;

    // Accumulate stage state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             err_reg, err_next;
    logic [13:0]      year_reg, year_next;
    logic [6:0]       cent_reg, cent_next;
    logic [6:0]       yy_reg, yy_next;
    logic [6:0]       month_reg, month_next;
    logic [6:0]       day_reg, day_next;
    logic [6:0]       hour_reg, hour_next;
    logic [6:0]       minute_reg, minute_next;

    // Handoff to the check stage
    logic             snap_valid_reg;
    dspv_snap_t       snap_reg, snap_next;

    // Output register
    logic             out_valid_reg;
    dspv_result_t     out_reg;
    dspv_result_t     check_res;

    logic             s_accept;
    logic             out_free;
    logic             snap_free;
    logic             is_digit;
    logic [3:0]       digit;
    logic [7:0]       digit_wide;

    // Output register frees when empty or taken; handoff frees when it can move
    assign out_free  = !out_valid_reg || m_tready;
    assign snap_free = !snap_valid_reg || out_free;
    assign s_tready  = snap_free;
    assign s_accept  = s_tvalid && s_tready;

    assign is_digit   = (s_tdata >= CHAR_ZERO) && (s_tdata <= CHAR_NINE);
    assign digit_wide = s_tdata - CHAR_ZERO;
    assign digit      = digit_wide[3:0];

    // Next accumulator state for the character at the channel
    always_comb begin
        err_next    = err_reg;
        year_next   = year_reg;
        cent_next   = cent_reg;
        yy_next     = yy_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;

        if (pos_reg < POS_TEXT_LEN) begin
            if (pos_reg == POS_DASH_A || pos_reg == POS_DASH_B) begin
                if (s_tdata != CHAR_DASH) err_next = 1'b1;
            end else if (pos_reg == POS_SLASH) begin
                if (s_tdata != CHAR_SLASH) err_next = 1'b1;
            end else if (pos_reg == POS_COLON) begin
                if (s_tdata != CHAR_COLON) err_next = 1'b1;
            end else if (!is_digit) begin
                err_next = 1'b1;
            end else if (pos_reg < POS_DASH_A) begin
                year_next = add_digit14(year_reg, digit);
                // Split the year into century and year-of-century for the leap rule
                if (pos_reg < POS_CENT_END) begin
                    cent_next = add_digit7(cent_reg, digit);
                end else begin
                    yy_next = add_digit7(yy_reg, digit);
                end
            end else if (pos_reg < POS_DASH_B) begin
                month_next = add_digit7(month_reg, digit);
            end else if (pos_reg < POS_SLASH) begin
                day_next = add_digit7(day_reg, digit);
            end else if (pos_reg < POS_COLON) begin
                hour_next = add_digit7(hour_reg, digit);
            end else begin
                minute_next = add_digit7(minute_reg, digit);
            end
        end

        // Saturate the position so overlong text stays invalid
        pos_next = (pos_reg < POS_MAX) ? pos_reg + 5'd1 : pos_reg;

        snap_next.fmt_ok  = (pos_next == POS_TEXT_LEN) && !err_next;
        snap_next.year    = year_next;
        snap_next.century = cent_next;
        snap_next.yy      = yy_next;
        snap_next.month   = month_next;
        snap_next.day     = day_next;
        snap_next.hour    = hour_next;
        snap_next.minute  = minute_next;
    end

    // Accumulate stage: advance on every character, clear after the last
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            err_reg    <= 1'b0;
            year_reg   <= '0;
            cent_reg   <= '0;
            yy_reg     <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
        end else if (s_accept) begin
            if (s_tlast) begin
                pos_reg    <= '0;
                err_reg    <= 1'b0;
                year_reg   <= '0;
                cent_reg   <= '0;
                yy_reg     <= '0;
                month_reg  <= '0;
                day_reg    <= '0;
                hour_reg   <= '0;
                minute_reg <= '0;
            end else begin
                pos_reg    <= pos_next;
                err_reg    <= err_next;
                year_reg   <= year_next;
                cent_reg   <= cent_next;
                yy_reg     <= yy_next;
                month_reg  <= month_next;
                day_reg    <= day_next;
                hour_reg   <= hour_next;
                minute_reg <= minute_next;
            end
        end
    end

    // Handoff register: load a finished text, hold while the output is stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else if (snap_free) begin
            snap_valid_reg <= s_accept && s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_free && s_accept && s_tlast) begin
            snap_reg <= snap_next;
        end
    end

    dspv_check u_check (
        .snap (snap_reg),
        .res  (check_res)
    );

    // Output register: hold the result until the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= snap_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && snap_valid_reg) begin
            out_reg <= check_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.ok;
    assign m_tdata  = {6'd0, out_reg.minute, out_reg.hour, out_reg.day,
                       out_reg.month, out_reg.year};

    // A failed text carries all-zero fields
    a_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == 40'd0))
        else $error("failed result with nonzero fields");

    // A passed text has month and time inside their ranges
    a_ranges_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[17:14] >= 4'd1 && m_tdata[17:14] <= 4'd12
                                   && m_tdata[27:23] <= 5'd23 && m_tdata[33:28] <= 6'd59))
        else $error("ok result out of range");

    // The last character restarts the position counter
    a_pos_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast) |=> (pos_reg == '0 && !err_reg))
        else $error("position not cleared after last character");

    // The position counter never passes its saturation value
    a_pos_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_MAX)
        else $error("position counter past saturation");

    // A waiting finished text is not lost while the output stalls
    a_snap_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (snap_valid_reg && !out_free) |=> (snap_valid_reg && $stable(snap_reg)))
        else $error("handoff register dropped a finished text");

endmodule

`default_nettype wire
